// ===== rtl/core/ffpra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpra_pkg
// Shared types and constants for the first-fit page range allocator.
// ----------------------------------------------------------------------------
package ffpra_pkg;

	localparam int PAGES_W   = 20;
	localparam int ADDR_W    = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [PAGES_W-1:0] PAGES_MAX = '1;

	localparam logic [ADDR_W-1:0] RST_REGION_START = 32'h0000_0000;
	localparam logic [ADDR_W-1:0] RST_REGION_END   = 32'h4000_0000;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 2'd1;

	typedef logic [PAGES_W-1:0] pages_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_NOSPACE  = 3'd2,
		ST_DOUBLE   = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

endpackage

// ===== rtl/core/ffpra_cell.sv =====
// ----------------------------------------------------------------------------
// ffpra_cell
// One segment slot of the ring: shifts its entry on towards the seam each
// scan cycle, or loads the rebuild value.
// ----------------------------------------------------------------------------
module ffpra_cell
	import ffpra_pkg::*;
#(
	parameter int            BASE_W    = 20,
	parameter logic          RST_VALID = 1'b0,
	parameter logic [BASE_W-1:0] RST_BASE = '0,
	parameter pages_t        RST_PAGES = '0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic              init,
	input  logic              d_valid,
	input  logic              d_used,
	input  logic [BASE_W-1:0] d_base,
	input  pages_t            d_pages,
	input  logic              init_valid,
	input  logic [BASE_W-1:0] init_base,
	input  pages_t            init_pages,
	output logic              q_valid,
	output logic              q_used,
	output logic [BASE_W-1:0] q_base,
	output pages_t            q_pages
);

	logic              valid_q;
	logic              used_q;
	logic [BASE_W-1:0] base_q;
	pages_t            pages_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= RST_VALID;
			used_q  <= 1'b0;
			base_q  <= RST_BASE;
			pages_q <= RST_PAGES;
		end else if (init) begin
			valid_q <= init_valid;
			used_q  <= 1'b0;
			base_q  <= init_base;
			pages_q <= init_pages;
		end else if (shift) begin
			valid_q <= d_valid;
			used_q  <= d_used;
			base_q  <= d_base;
			pages_q <= d_pages;
		end
	end

	assign q_valid = valid_q;
	assign q_used  = used_q;
	assign q_base  = base_q;
	assign q_pages = pages_q;

endmodule

// ===== rtl/core/first_fit_page_range_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_page_range_allocator
// Address-ordered segment table kept in a ring of cells; each item rotates
// the whole table once past the seam, where first fit, split and free act.
// ----------------------------------------------------------------------------
// channel   signals                                   handshake
// item in   command, request_pages, free_addr         start & !busy
// result    alloc_addr, status                        done, one cycle
// config    cfg_index, cfg_wdata                      cfg_we
//
// From accept to result the table makes one full turn of the cell ring,
// one entry past the seam per cycle. busy falls in the cycle that done is
// high, so the next item may follow. Reset and any write to the region
// start or end register load the table as one free segment. The receiver
// cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module first_fit_page_range_allocator
	import ffpra_pkg::*;
#(
	parameter int MAX_SEGMENTS = 64,
	parameter int PAGE_SHIFT   = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 command,
	input  pages_t               request_pages,
	input  logic [ADDR_W-1:0]    free_addr,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	output logic                 done,
	output logic [ADDR_W-1:0]    alloc_addr,
	output logic [2:0]           status
);

	localparam int BASE_W = ADDR_W - PAGE_SHIFT;
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int IDX_W  = $clog2(MAX_SEGMENTS);

	localparam logic [ADDR_W-1:0] RST_SPAN =
		(RST_REGION_END - RST_REGION_START) >> PAGE_SHIFT;
	localparam pages_t RST_PAGES = (RST_REGION_END <= RST_REGION_START) ? '0 :
		((RST_SPAN > ADDR_W'(PAGES_MAX)) ? PAGES_MAX : PAGES_W'(RST_SPAN));
	localparam logic [BASE_W-1:0] RST_BASE = RST_REGION_START[ADDR_W-1:PAGE_SHIFT];
	localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(MAX_SEGMENTS);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_SEGMENTS - 1);

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	// region registers and rebuild value
	logic [ADDR_W-1:0] start_addr_q, end_addr_q;
	logic [ADDR_W-1:0] new_start, new_end, span;
	logic              rebuild;
	logic [BASE_W-1:0] init_base;
	pages_t            init_pages;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_addr_q <= RST_REGION_START;
			end_addr_q   <= RST_REGION_END;
		end else if (cfg_we) begin
			if (cfg_index == REG_REGION_START) start_addr_q <= cfg_wdata;
			if (cfg_index == REG_REGION_END)   end_addr_q   <= cfg_wdata;
		end
	end

	always_comb begin
		rebuild   = cfg_we && (cfg_index == REG_REGION_START || cfg_index == REG_REGION_END);
		new_start = (cfg_index == REG_REGION_START) ? cfg_wdata : start_addr_q;
		new_end   = (cfg_index == REG_REGION_END) ? cfg_wdata : end_addr_q;
		span      = (new_end - new_start) >> PAGE_SHIFT;
		init_base = new_start[ADDR_W-1:PAGE_SHIFT];
		if (new_end <= new_start)
			init_pages = '0;
		else if (span > ADDR_W'(PAGES_MAX))
			init_pages = PAGES_MAX;
		else
			init_pages = PAGES_W'(span);
	end

	// cell ring
	logic              c_valid [MAX_SEGMENTS];
	logic              c_used  [MAX_SEGMENTS];
	logic [BASE_W-1:0] c_base  [MAX_SEGMENTS];
	pages_t            c_pages [MAX_SEGMENTS];

	logic              w_valid, w_used;
	logic [BASE_W-1:0] w_base;
	pages_t            w_pages;

	state_t state_q;
	logic   scanning;

	assign scanning = (state_q == S_SCAN);

	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		logic              d_valid, d_used;
		logic [BASE_W-1:0] d_base;
		pages_t            d_pages;

		if (i == MAX_SEGMENTS - 1) begin : g_tail
			assign d_valid = w_valid;
			assign d_used  = w_used;
			assign d_base  = w_base;
			assign d_pages = w_pages;
		end else begin : g_mid
			assign d_valid = c_valid[i+1];
			assign d_used  = c_used[i+1];
			assign d_base  = c_base[i+1];
			assign d_pages = c_pages[i+1];
		end

		ffpra_cell #(
			.BASE_W    (BASE_W),
			.RST_VALID (i == 0),
			.RST_BASE  ((i == 0) ? RST_BASE : '0),
			.RST_PAGES ((i == 0) ? RST_PAGES : '0)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (scanning),
			.init       (rebuild),
			.d_valid    (d_valid),
			.d_used     (d_used),
			.d_base     (d_base),
			.d_pages    (d_pages),
			.init_valid (i == 0),
			.init_base  ((i == 0) ? init_base : '0),
			.init_pages ((i == 0) ? init_pages : '0),
			.q_valid    (c_valid[i]),
			.q_used     (c_used[i]),
			.q_base     (c_base[i]),
			.q_pages    (c_pages[i])
		);
	end

	// seam
	logic              cmd_q;
	pages_t            req_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic              found_q, hold_q;
	logic              hold_valid_q, hold_used_q;
	logic [BASE_W-1:0] hold_base_q;
	pages_t            hold_pages_q;
	status_t           st_q, st_next, res_st;
	logic [ADDR_W-1:0] addr_q, addr_next;
	logic              done_q;
	logic [ADDR_W-1:0] alloc_addr_q;
	status_t           status_q;

	logic              fit, split, full, match, start_hold, found_now;
	logic              m_valid, m_used;
	logic [BASE_W-1:0] m_base;
	pages_t            m_pages;
	logic [ADDR_W-1:0] base_sum;

	always_comb begin
		full  = (count_q == FULL_CNT);
		fit   = (cmd_q == CMD_ALLOC) && (req_q != '0) && !found_q && c_valid[0] &&
			!c_used[0] && (c_pages[0] >= req_q);
		split = fit && (c_pages[0] != req_q);
		match = (cmd_q == CMD_FREE) && !found_q && c_valid[0] &&
			(faddr_q[PAGE_SHIFT-1:0] == '0) && (faddr_q[ADDR_W-1:PAGE_SHIFT] == c_base[0]);
		start_hold = split && !full;
		base_sum   = ADDR_W'(c_base[0]) + ADDR_W'(req_q);

		m_valid   = c_valid[0];
		m_used    = c_used[0];
		m_base    = c_base[0];
		m_pages   = c_pages[0];
		st_next   = st_q;
		addr_next = addr_q;
		if (fit) begin
			if (split && full) begin
				st_next = ST_FULL;
			end else begin
				st_next   = ST_OK;
				addr_next = {c_base[0], {PAGE_SHIFT{1'b0}}};
				m_used    = 1'b1;
				if (split) m_pages = req_q;
			end
		end
		if (match) begin
			if (c_used[0]) begin
				st_next = ST_OK;
				m_used  = 1'b0;
			end else begin
				st_next = ST_DOUBLE;
			end
		end

		if (hold_q) begin
			w_valid = hold_valid_q;
			w_used  = hold_used_q;
			w_base  = hold_base_q;
			w_pages = hold_pages_q;
		end else begin
			w_valid = m_valid;
			w_used  = m_used;
			w_base  = m_base;
			w_pages = m_pages;
		end

		found_now = found_q || fit || match;
		if (cmd_q == CMD_ALLOC && req_q == '0)
			res_st = ST_ZERO;
		else if (!found_now)
			res_st = (cmd_q == CMD_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
		else
			res_st = st_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CNT_W'(1);
			found_q <= 1'b0;
			hold_q  <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (rebuild) count_q <= CNT_W'(1);
					if (start) begin
						state_q <= S_SCAN;
						cmd_q   <= command;
						req_q   <= request_pages;
						faddr_q <= free_addr;
						idx_q   <= '0;
						found_q <= 1'b0;
						hold_q  <= 1'b0;
						st_q    <= ST_OK;
						addr_q  <= '0;
					end
				end
				S_SCAN: begin
					found_q <= found_now;
					st_q    <= st_next;
					addr_q  <= addr_next;
					if (hold_q) begin
						hold_valid_q <= c_valid[0];
						hold_used_q  <= c_used[0];
						hold_base_q  <= c_base[0];
						hold_pages_q <= c_pages[0];
					end else begin
						hold_valid_q <= 1'b1;
						hold_used_q  <= 1'b0;
						hold_base_q  <= base_sum[BASE_W-1:0];
						hold_pages_q <= c_pages[0] - req_q;
					end
					if (start_hold) begin
						hold_q  <= 1'b1;
						count_q <= count_q + CNT_W'(1);
					end
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == LAST_IDX) begin
						state_q      <= S_IDLE;
						done_q       <= 1'b1;
						status_q     <= res_st;
						alloc_addr_q <= (res_st == ST_OK) ? addr_next : '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = scanning;
	assign done       = done_q;
	assign alloc_addr = alloc_addr_q;
	assign status     = status_q;

endmodule

// ===== sim/first_fit_page_range_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_page_range_allocator_tb
// Self-checking bench for the first-fit page range allocator. A table of
// directed items and register writes covers zero, full-width and exact-fit
// requests, double and unknown frees and empty, inverted and full-span
// regions. Random phases follow: each one sets a new region, then sends
// mostly small allocates and frees of live segments, which pushes the
// segment table to full. Every result is checked against the expected value
// of its directed row if it has one, else a predictor kept in the bench.
// ----------------------------------------------------------------------------
module first_fit_page_range_allocator_tb;
	import ffpra_pkg::*;

	localparam int SEGS        = 64;
	localparam int PAGE_SHIFT  = 12;
	localparam int LIMIT       = 1000000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 143;
	localparam int DIR_ROWS    = 26;

	localparam logic [CFG_IDX_W-1:0] IDX_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE3 = 2'd3;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           st;
	} alloc_result_t;

	typedef struct packed {
		row_kind_t            kind;
		logic                 cmd;
		pages_t               pages;
		logic [ADDR_W-1:0]    word;
		logic [CFG_IDX_W-1:0] idx;
		logic                 typed;
		logic [ADDR_W-1:0]    exp_addr;
		status_t              exp_st;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 command = CMD_ALLOC;
	pages_t               request_pages = '0;
	logic [ADDR_W-1:0]    free_addr = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_REGION_START;
	logic [ADDR_W-1:0]    cfg_wdata = '0;
	logic                 done;
	logic [ADDR_W-1:0]    alloc_addr;
	logic [2:0]           status;

	// bench copy of the segment table
	logic [ADDR_W-1:0] region_lo;
	logic [ADDR_W-1:0] region_hi;
	pages_t            seg_base [SEGS];
	pages_t            seg_len [SEGS];
	logic              seg_taken [SEGS];
	int                seg_total;

	alloc_result_t pending_results [$];
	alloc_result_t oldest_result;
	int            errors = 0;
	int            cycles = 0;
	bit            idle_en = 1'b1;

	step_row_t directed [DIR_ROWS] = '{
		'{ROW_ITEM, CMD_ALLOC, 20'h00000, 32'h0, REG_REGION_START, 1'b1, 32'h0, ST_ZERO},
		'{ROW_ITEM, CMD_ALLOC, 20'h00001, 32'h0, REG_REGION_START, 1'b1, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_ALLOC, 20'hFFFFF, 32'h0, REG_REGION_START, 1'b1, 32'h0, ST_NOSPACE},
		'{ROW_ITEM, CMD_FREE, 20'h00000, 32'h0, REG_REGION_START, 1'b1, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_FREE, 20'h00000, 32'h0, REG_REGION_START, 1'b1, 32'h0, ST_DOUBLE},
		'{ROW_ITEM, CMD_FREE, 20'h00000, 32'h800, REG_REGION_START, 1'b1, 32'h0, ST_NOTFOUND},
		'{ROW_ITEM, CMD_FREE, 20'h00000, 32'hFFFFFFFF, REG_REGION_START, 1'b1, 32'h0,
			ST_NOTFOUND},
		'{ROW_ITEM, CMD_ALLOC, 20'h3FFFF, 32'h0, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_ALLOC, 20'h00001, 32'h0, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_ALLOC, 20'h00001, 32'h0, REG_REGION_START, 1'b1, 32'h0, ST_NOSPACE},
		'{ROW_CFG, CMD_ALLOC, 20'h00000, 32'hFFFFFFFF, IDX_SPARE2, 1'b0, 32'h0, ST_OK},
		'{ROW_CFG, CMD_ALLOC, 20'h00000, 32'h0, IDX_SPARE3, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_FREE, 20'h00000, 32'h1000, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_CFG, CMD_ALLOC, 20'h00000, 32'hFFFFF000, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_ALLOC, 20'h00001, 32'h0, REG_REGION_START, 1'b1, 32'h0, ST_NOSPACE},
		'{ROW_ITEM, CMD_FREE, 20'h00000, 32'hFFFFF000, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_CFG, CMD_ALLOC, 20'h00000, 32'h00000FFF, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_CFG, CMD_ALLOC, 20'h00000, 32'hFFFFFFFF, REG_REGION_END, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_ALLOC, 20'hFFFFF, 32'h0, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_FREE, 20'h00000, 32'h0, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_ALLOC, 20'h80000, 32'h0, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_ALLOC, 20'h7FFFF, 32'h0, REG_REGION_START, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_ALLOC, 20'h00001, 32'h0, REG_REGION_START, 1'b1, 32'h0, ST_NOSPACE},
		'{ROW_CFG, CMD_ALLOC, 20'h00000, 32'h0, REG_REGION_END, 1'b0, 32'h0, ST_OK},
		'{ROW_ITEM, CMD_ALLOC, 20'hFFFFF, 32'h0, REG_REGION_START, 1'b1, 32'h0, ST_NOSPACE},
		'{ROW_ITEM, CMD_FREE, 20'h00000, 32'h0, REG_REGION_START, 1'b0, 32'h0, ST_OK}
	};

	first_fit_page_range_allocator #(
		.MAX_SEGMENTS(SEGS),
		.PAGE_SHIFT  (PAGE_SHIFT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.request_pages(request_pages),
		.free_addr    (free_addr),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.alloc_addr   (alloc_addr),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] page_addr(input pages_t pg);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(pg);
		return a << PAGE_SHIFT;
	endfunction

	function automatic void rebuild_region();
		logic [ADDR_W-1:0] span;
		for (int i = 0; i < SEGS; i++) begin
			seg_base[i] = '0;
			seg_len[i] = '0;
			seg_taken[i] = 1'b0;
		end
		if (region_hi > region_lo) begin
			span = (region_hi - region_lo) >> PAGE_SHIFT;
			seg_len[0] = (span > PAGES_MAX) ? PAGES_MAX : pages_t'(span);
		end
		seg_base[0] = pages_t'(region_lo >> PAGE_SHIFT);
		seg_total = 1;
	endfunction

	function automatic void write_region(input logic [CFG_IDX_W-1:0] idx,
			input logic [ADDR_W-1:0] data);
		if (idx == REG_REGION_START) begin
			region_lo = data;
			rebuild_region();
		end else if (idx == REG_REGION_END) begin
			region_hi = data;
			rebuild_region();
		end
	endfunction

	function automatic alloc_result_t first_fit_alloc(input pages_t req);
		alloc_result_t res;
		int hit;
		res.addr = '0;
		res.st = ST_OK;
		hit = -1;
		for (int i = 0; i < seg_total; i++)
			if (hit < 0 && !seg_taken[i] && seg_len[i] >= req)
				hit = i;
		if (req == '0) begin
			res.st = ST_ZERO;
		end else if (hit < 0) begin
			res.st = ST_NOSPACE;
		end else if (seg_len[hit] > req && seg_total >= SEGS) begin
			res.st = ST_FULL;
		end else begin
			if (seg_len[hit] > req) begin
				for (int k = seg_total; k > hit + 1; k--) begin
					seg_base[k] = seg_base[k-1];
					seg_len[k] = seg_len[k-1];
					seg_taken[k] = seg_taken[k-1];
				end
				seg_base[hit+1] = seg_base[hit] + req;
				seg_len[hit+1] = seg_len[hit] - req;
				seg_taken[hit+1] = 1'b0;
				seg_len[hit] = req;
				seg_total++;
			end
			seg_taken[hit] = 1'b1;
			res.addr = page_addr(seg_base[hit]);
		end
		return res;
	endfunction

	function automatic alloc_result_t release_segment(input logic [ADDR_W-1:0] a);
		alloc_result_t res;
		int hit;
		res.addr = '0;
		res.st = ST_NOTFOUND;
		hit = -1;
		for (int i = 0; i < seg_total; i++)
			if (hit < 0 && page_addr(seg_base[i]) == a)
				hit = i;
		if (hit >= 0) begin
			res.st = seg_taken[hit] ? ST_OK : ST_DOUBLE;
			seg_taken[hit] = 1'b0;
		end
		return res;
	endfunction

	task automatic issue_item(input logic cmd, input pages_t pages,
			input logic [ADDR_W-1:0] a, input logic typed, input alloc_result_t typed_res);
		alloc_result_t res;
		int gap;
		gap = 0;
		if (idle_en && $urandom_range(0, 99) < 36)
			gap = $urandom_range(1, 90);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		request_pages <= pages;
		free_addr <= a;
		do @(posedge clk); while (busy);
		if (cmd == CMD_ALLOC)
			res = first_fit_alloc(pages);
		else
			res = release_segment(a);
		pending_results.push_back(typed ? typed_res : res);
	endtask

	// only between items, once every result is back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		write_region(idx, data);
		@(posedge clk);
	endtask

	task automatic program_region();
		logic [ADDR_W-1:0] lo, hi;
		lo = $urandom & 32'hFFFFF000;
		hi = lo + ($urandom_range(64, 2048) << PAGE_SHIFT);
		case ($urandom_range(0, 5))
			3: begin
				lo = '0;
				hi = '1;
			end
			4: begin
				lo = $urandom;
				hi = $urandom;
			end
			5: hi = lo - ($urandom_range(0, 1) << PAGE_SHIFT);
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? IDX_SPARE2 : IDX_SPARE3, $urandom);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_REGION_START, lo);
			write_reg(REG_REGION_END, hi);
		end else begin
			write_reg(REG_REGION_END, hi);
			write_reg(REG_REGION_START, lo);
		end
	endtask

	task automatic random_item();
		int r, j;
		alloc_result_t none;
		none = '0;
		r = $urandom_range(0, 99);
		j = $urandom_range(0, seg_total - 1);
		if (r < 52)
			issue_item(CMD_ALLOC, pages_t'($urandom_range(1, 12)), $urandom, 1'b0, none);
		else if (r < 58)
			issue_item(CMD_ALLOC, pages_t'($urandom_range(0, PAGES_MAX)), $urandom, 1'b0, none);
		else if (r < 61)
			issue_item(CMD_ALLOC, '0, $urandom, 1'b0, none);
		else if (r < 66)
			issue_item(CMD_ALLOC, seg_len[j], $urandom, 1'b0, none);
		else if (r < 88)
			issue_item(CMD_FREE, pages_t'($urandom), page_addr(seg_base[j]), 1'b0, none);
		else if (r < 93)
			issue_item(CMD_FREE, pages_t'($urandom),
				page_addr(seg_base[j]) + $urandom_range(1, 4095), 1'b0, none);
		else
			issue_item(CMD_FREE, pages_t'($urandom), $urandom, 1'b0, none);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, got addr %h status %0d",
					$time, alloc_addr, status);
			end else begin
				oldest_result = pending_results.pop_front();
				if (alloc_addr !== oldest_result.addr) begin
					errors++;
					$display("%0t: alloc_addr: expected %h, got %h",
						$time, oldest_result.addr, alloc_addr);
				end
				if (status !== oldest_result.st) begin
					errors++;
					$display("%0t: status: expected %0d, got %0d",
						$time, oldest_result.st, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("first_fit_page_range_allocator_tb: errors");
			$finish;
		end
	end

	initial begin
		step_row_t row;
		alloc_result_t typed_res;
		region_lo = RST_REGION_START;
		region_hi = RST_REGION_END;
		rebuild_region();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = directed[i];
			typed_res.addr = row.exp_addr;
			typed_res.st = row.exp_st;
			if (row.kind == ROW_CFG)
				write_reg(row.idx, row.word);
			else
				issue_item(row.cmd, row.pages, row.word, row.typed, typed_res);
		end

		for (int p = 0; p < PHASES; p++) begin
			idle_en = (p != 4);
			program_region();
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SEGS + 10) @(posedge clk);
		if (errors == 0)
			$display("first_fit_page_range_allocator_tb: clean");
		else
			$display("first_fit_page_range_allocator_tb: errors");
		$finish;
	end

endmodule
